@@ rtl/fdtd_pkg.sv @@
// ----------------------------------------------------------------------------
// fdtd_pkg
// Shared types, sizes and helper functions for the FDTD magnetic field update.
// ----------------------------------------------------------------------------
package fdtd_pkg;

    // Grid limits and field format.
    localparam int MAX_X      = 1024;
    localparam int MAX_Y      = 64;
    localparam int MAX_Z      = 64;
    localparam int FIELD_BITS = 32;
    localparam int COEF_W     = 32;
    localparam int FRAC_SHIFT = 32;

    // Register widths.
    localparam int CELLS_X_W = 11;
    localparam int CELLS_Y_W = 7;
    localparam int CELLS_Z_W = 7;
    localparam int SIZE_W    = 11;

    // APB register map: four registers on the 32-bit data bus at byte addresses 0, 4, 8 and 12.
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 2;

    // Scan position widths.
    localparam int POS_X_W = (MAX_X > 1) ? $clog2(MAX_X) : 1;
    localparam int POS_Y_W = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
    localparam int POS_Z_W = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;

    // Plane store geometry.
    localparam int PLANE_DEPTH = MAX_Y * MAX_Z;
    localparam int ADDR_W      = (PLANE_DEPTH > 1) ? $clog2(PLANE_DEPTH) : 1;

    // Arithmetic widths: a four-term curl difference, its product with the
    // coefficient, and the sum before saturation.
    localparam int DIFF_W = FIELD_BITS + 2;
    localparam int PROD_W = DIFF_W + COEF_W;
    localparam int SUM_W  = DIFF_W + 2;

    typedef logic signed [FIELD_BITS-1:0] t_field;
    typedef logic signed [DIFF_W-1:0]     t_diff;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_COEF    = 2'd0,
        REG_CELLS_X = 2'd1,
        REG_CELLS_Y = 2'd2,
        REG_CELLS_Z = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [COEF_W-1:0]    update_coefficient;
        logic [CELLS_X_W-1:0] cells_x;
        logic [CELLS_Y_W-1:0] cells_y;
        logic [CELLS_Z_W-1:0] cells_z;
    } t_cfg;

    typedef struct packed {
        t_field ex_in;
        t_field ey_in;
        t_field ez_in;
        t_field hx_in;
        t_field hy_in;
        t_field hz_in;
    } t_in_item;

    typedef struct packed {
        t_field hx_out;
        t_field hy_out;
        t_field hz_out;
        logic   saturated;
        logic   grid_done;
    } t_out_item;

    typedef struct packed {
        t_field ex;
        t_field ey;
        t_field ez;
    } t_evec;

    // Boundary status of the cell being accepted.
    typedef struct packed {
        logic nx_ok;
        logic ny_ok;
        logic nz_ok;
        logic last;
    } t_bound;

    typedef struct packed {
        logic [ADDR_W-1:0] addr_cur;
        logic [ADDR_W-1:0] addr_ny;
        t_bound            bound;
    } t_scan_info;

    // Clamp a size register to 1..hi.
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] hi);
        logic [SIZE_W-1:0] r;
        if (v == '0) begin
            r = SIZE_W'(1);
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Four-term difference a - b - c + e at full precision.
    function automatic t_diff curl_diff(input t_field a, input t_field b,
                                        input t_field c, input t_field e);
        t_diff r;
        r = DIFF_W'(a) - DIFF_W'(b) - DIFF_W'(c) + DIFF_W'(e);
        return r;
    endfunction

endpackage

@@ rtl/fdtd_cfg.sv @@
// ----------------------------------------------------------------------------
// fdtd_cfg
// APB register file holding the update coefficient and the grid sizes.
// ----------------------------------------------------------------------------
module fdtd_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fdtd_pkg::PADDR_W-1:0]    paddr,
    input  logic [fdtd_pkg::PDATA_W-1:0]    pwdata,
    output logic [fdtd_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready,
    output fdtd_pkg::t_cfg                  o_cfg,
    output fdtd_pkg::t_cfg                  o_cfg_next,
    output logic                            o_restart
);
    import fdtd_pkg::*;

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx reg_idx;
    logic     wr;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[REG_IDX_W+1:2]);
    assign wr      = psel & penable & pwrite;

    always_comb begin
        n_cfg     = r_cfg;
        o_restart = 1'b0;
        if (wr) begin
            case (reg_idx)
                REG_COEF: begin
                    n_cfg.update_coefficient = pwdata[COEF_W-1:0];
                end
                REG_CELLS_X: begin
                    n_cfg.cells_x = pwdata[CELLS_X_W-1:0];
                    o_restart     = 1'b1;
                end
                REG_CELLS_Y: begin
                    n_cfg.cells_y = pwdata[CELLS_Y_W-1:0];
                    o_restart     = 1'b1;
                end
                REG_CELLS_Z: begin
                    n_cfg.cells_z = pwdata[CELLS_Z_W-1:0];
                    o_restart     = 1'b1;
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.update_coefficient <= '0;
            r_cfg.cells_x            <= CELLS_X_W'(1);
            r_cfg.cells_y            <= CELLS_Y_W'(1);
            r_cfg.cells_z            <= CELLS_Z_W'(1);
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (reg_idx)
            REG_COEF:    prdata = PDATA_W'(r_cfg.update_coefficient);
            REG_CELLS_X: prdata = PDATA_W'(r_cfg.cells_x);
            REG_CELLS_Y: prdata = PDATA_W'(r_cfg.cells_y);
            REG_CELLS_Z: prdata = PDATA_W'(r_cfg.cells_z);
            default:     prdata = '0;
        endcase
    end

    assign o_cfg      = r_cfg;
    assign o_cfg_next = n_cfg;

endmodule

@@ rtl/fdtd_scan.sv @@
// ----------------------------------------------------------------------------
// fdtd_scan
// Raster position counters, boundary flags and plane store addresses.
// ----------------------------------------------------------------------------
module fdtd_scan (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  fdtd_pkg::t_cfg         i_cfg,
    input  fdtd_pkg::t_cfg         i_cfg_next,
    input  logic                   i_restart,
    input  logic                   i_advance,
    output fdtd_pkg::t_scan_info   o_info
);
    import fdtd_pkg::*;

    logic [POS_X_W-1:0] r_x, n_x;
    logic [POS_Y_W-1:0] r_y, n_y;
    logic [POS_Z_W-1:0] r_z, n_z;

    logic [SIZE_W-1:0] eff_x, eff_y, eff_z;
    logic [SIZE_W-1:0] nxt_x, nxt_y, nxt_z;
    logic [SIZE_W-1:0] top_x, top_y, top_z;
    logic [SIZE_W-1:0] rst_x, rst_y, rst_z;

    assign eff_x = eff_size(SIZE_W'(i_cfg.cells_x), SIZE_W'(MAX_X));
    assign eff_y = eff_size(SIZE_W'(i_cfg.cells_y), SIZE_W'(MAX_Y));
    assign eff_z = eff_size(SIZE_W'(i_cfg.cells_z), SIZE_W'(MAX_Z));
    assign nxt_x = eff_size(SIZE_W'(i_cfg_next.cells_x), SIZE_W'(MAX_X));
    assign nxt_y = eff_size(SIZE_W'(i_cfg_next.cells_y), SIZE_W'(MAX_Y));
    assign nxt_z = eff_size(SIZE_W'(i_cfg_next.cells_z), SIZE_W'(MAX_Z));

    // Highest index along each axis for the running grid and the restarted one.
    assign top_x = eff_x - SIZE_W'(1);
    assign top_y = eff_y - SIZE_W'(1);
    assign top_z = eff_z - SIZE_W'(1);
    assign rst_x = nxt_x - SIZE_W'(1);
    assign rst_y = nxt_y - SIZE_W'(1);
    assign rst_z = nxt_z - SIZE_W'(1);

    always_comb begin
        n_x = r_x;
        n_y = r_y;
        n_z = r_z;
        if (i_restart) begin
            n_x = rst_x[POS_X_W-1:0];
            n_y = rst_y[POS_Y_W-1:0];
            n_z = rst_z[POS_Z_W-1:0];
        end else if (i_advance) begin
            if (r_z != '0) begin
                n_z = r_z - POS_Z_W'(1);
            end else begin
                n_z = top_z[POS_Z_W-1:0];
                if (r_y != '0) begin
                    n_y = r_y - POS_Y_W'(1);
                end else begin
                    n_y = top_y[POS_Y_W-1:0];
                    n_x = (r_x != '0) ? r_x - POS_X_W'(1) : top_x[POS_X_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= '0;
            r_y <= '0;
            r_z <= '0;
        end else begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    always_comb begin
        o_info.bound.nx_ok = (r_x != top_x[POS_X_W-1:0]);
        o_info.bound.ny_ok = (r_y != top_y[POS_Y_W-1:0]);
        o_info.bound.nz_ok = (r_z != top_z[POS_Z_W-1:0]);
        o_info.bound.last  = (r_x == '0) && (r_y == '0) && (r_z == '0);
        o_info.addr_cur    = ADDR_W'(ADDR_W'(r_y) * ADDR_W'(MAX_Z)) + ADDR_W'(r_z);
        // The y+1 neighbor lies one row further on; on the far y plane it is
        // not used, so the address stays in range.
        o_info.addr_ny     = o_info.bound.ny_ok ?
                             o_info.addr_cur + ADDR_W'(MAX_Z) : o_info.addr_cur;
    end

endmodule

@@ rtl/fdtd_plane_mem.sv @@
// ----------------------------------------------------------------------------
// fdtd_plane_mem
// One y-z plane of E vectors: one write port and two registered read ports.
// ----------------------------------------------------------------------------
module fdtd_plane_mem (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [fdtd_pkg::ADDR_W-1:0]    i_waddr,
    input  fdtd_pkg::t_evec                i_wdata,
    input  logic                           i_re,
    input  logic [fdtd_pkg::ADDR_W-1:0]    i_raddr_a,
    input  logic [fdtd_pkg::ADDR_W-1:0]    i_raddr_b,
    output fdtd_pkg::t_evec                o_rdata_a,
    output fdtd_pkg::t_evec                o_rdata_b
);
    import fdtd_pkg::*;

    t_evec mem [PLANE_DEPTH];
    t_evec r_qa;
    t_evec r_qb;

    // A read at the address being written returns the older contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_qa <= mem[i_raddr_a];
            r_qb <= mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_qa;
    assign o_rdata_b = r_qb;

endmodule

@@ rtl/fdtd_h_update.sv @@
// ----------------------------------------------------------------------------
// fdtd_h_update
// One H component: magnitude, coefficient product, rounding and saturation.
// ----------------------------------------------------------------------------
module fdtd_h_update (
    input  logic                           i_clk,
    input  logic                           i_en_mag,
    input  logic                           i_en_mul,
    input  logic                           i_upd,
    input  fdtd_pkg::t_field               i_h,
    input  fdtd_pkg::t_diff                i_d,
    input  logic [fdtd_pkg::COEF_W-1:0]    i_coef,
    output fdtd_pkg::t_field               o_h,
    output logic                           o_sat
);
    import fdtd_pkg::*;

    localparam int Q_W = PROD_W + 1 - FRAC_SHIFT;

    logic [DIFF_W-1:0] r_mag;
    logic              r_neg_a;
    logic              r_upd_a;
    t_field            r_h_a;

    logic [PROD_W-1:0] r_prod;
    logic              r_neg_b;
    logic              r_upd_b;
    t_field            r_h_b;

    logic [PROD_W:0]         rnd;
    logic [Q_W-1:0]          q;
    logic signed [SUM_W-1:0] inc;
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] fmax;
    logic signed [SUM_W-1:0] fmin;

    always_ff @(posedge i_clk) begin
        if (i_en_mag) begin
            r_mag   <= i_d[DIFF_W-1] ? DIFF_W'(-i_d) : DIFF_W'(i_d);
            r_neg_a <= i_d[DIFF_W-1];
            r_upd_a <= i_upd;
            r_h_a   <= i_h;
        end
        if (i_en_mul) begin
            r_prod  <= PROD_W'(r_mag) * PROD_W'(i_coef);
            r_neg_b <= r_neg_a;
            r_upd_b <= r_upd_a;
            r_h_b   <= r_h_a;
        end
    end

    // Rounding on the magnitude gives round half away from zero on the value.
    assign rnd  = (PROD_W + 1)'(r_prod) + ((PROD_W + 1)'(1) << (FRAC_SHIFT - 1));
    assign q    = rnd[PROD_W:FRAC_SHIFT];
    assign inc  = r_neg_b ? -SUM_W'(q) : SUM_W'(q);
    assign sum  = SUM_W'(r_h_b) + inc;
    assign fmax = SUM_W'({1'b0, {(FIELD_BITS - 1){1'b1}}});
    assign fmin = -fmax - SUM_W'(1);

    always_comb begin
        o_h   = r_h_b;
        o_sat = 1'b0;
        if (r_upd_b) begin
            if (sum > fmax) begin
                o_h   = fmax[FIELD_BITS-1:0];
                o_sat = 1'b1;
            end else if (sum < fmin) begin
                o_h   = fmin[FIELD_BITS-1:0];
                o_sat = 1'b1;
            end else begin
                o_h = sum[FIELD_BITS-1:0];
            end
        end
    end

endmodule

@@ rtl/fdtd_magnetic_field_update_top.sv @@
// ----------------------------------------------------------------------------
// fdtd_magnetic_field_update_top
// H-field half step of a 3-D Yee grid, streaming one cell per clock while the output does not stall.
// ----------------------------------------------------------------------------
// Cells enter in descending raster order (x outer, z inner) and the block
// takes one cell in every clock cycle while the output does not stall. A
// cell passes stage one, the magnitude and product registers and then the
// result register. The rate is set by the plane store, which takes one write
// and two reads per cycle: the y+1 and x+1 neighbors come from the store,
// and the z+1 neighbor is the previous cell held in a register. After the
// store read, each component goes through a magnitude stage, a 34x32 product
// stage and a round, add and saturate stage. Writing a size register restarts
// the scan at the top corner; the coefficient may be changed between cells.
// Program registers only while no transaction is in flight.
module fdtd_magnetic_field_update_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fdtd_pkg::PADDR_W-1:0]  paddr,
    input  logic [fdtd_pkg::PDATA_W-1:0]  pwdata,
    output logic [fdtd_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  fdtd_pkg::t_in_item            i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output fdtd_pkg::t_out_item           o_out_data
);
    import fdtd_pkg::*;

    t_cfg       cfg;
    t_cfg       cfg_next;
    logic       restart;
    t_scan_info scan;

    logic accept;
    logic adv2, adv3, load_out;

    logic r_v1, r_v2, r_v3, r_vo;

    t_in_item  r_s1;
    t_bound    r_s1_bound;
    t_evec     r_nz;
    t_evec     ny;
    t_evec     nx;
    logic      r_s2_done;
    logic      r_s3_done;
    t_out_item r_out;

    t_diff  d_hx, d_hy, d_hz;
    t_field hx, hy, hz;
    logic   sat_x, sat_y, sat_z;
    t_evec  cur_e;

    fdtd_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_cfg      (cfg),
        .o_cfg_next (cfg_next),
        .o_restart  (restart)
    );

    fdtd_scan u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_cfg_next (cfg_next),
        .i_restart  (restart),
        .i_advance  (accept),
        .o_info     (scan)
    );

    // Pipeline flow: each stage moves on when the next one is empty or moving.
    assign load_out   = r_v3 & (~r_vo | i_out_ready);
    assign adv3       = r_v2 & (~r_v3 | load_out);
    assign adv2       = r_v1 & (~r_v2 | adv3);
    assign o_in_ready = ~r_v1 | adv2;
    assign accept     = i_in_valid & o_in_ready;

    assign cur_e.ex = i_in_data.ex_in;
    assign cur_e.ey = i_in_data.ey_in;
    assign cur_e.ez = i_in_data.ez_in;

    fdtd_plane_mem u_plane (
        .i_clk     (i_clk),
        .i_we      (accept),
        .i_waddr   (scan.addr_cur),
        .i_wdata   (cur_e),
        .i_re      (accept),
        .i_raddr_a (scan.addr_ny),
        .i_raddr_b (scan.addr_cur),
        .o_rdata_a (ny),
        .o_rdata_b (nx)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (accept) begin
                r_v1 <= 1'b1;
            end else if (adv2) begin
                r_v1 <= 1'b0;
            end
            if (adv2) begin
                r_v2 <= 1'b1;
            end else if (adv3) begin
                r_v2 <= 1'b0;
            end
            if (adv3) begin
                r_v3 <= 1'b1;
            end else if (load_out) begin
                r_v3 <= 1'b0;
            end
            if (load_out) begin
                r_vo <= 1'b1;
            end else if (i_out_ready) begin
                r_vo <= 1'b0;
            end
        end
    end

    // Stage one holds the last accepted cell, so on acceptance it is the
    // z+1 neighbor of the incoming one.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1       <= i_in_data;
            r_s1_bound <= scan.bound;
            r_nz.ex    <= r_s1.ex_in;
            r_nz.ey    <= r_s1.ey_in;
            r_nz.ez    <= r_s1.ez_in;
        end
        if (adv2) begin
            r_s2_done <= r_s1_bound.last;
        end
        if (adv3) begin
            r_s3_done <= r_s2_done;
        end
        if (load_out) begin
            r_out.hx_out    <= hx;
            r_out.hy_out    <= hy;
            r_out.hz_out    <= hz;
            r_out.saturated <= sat_x | sat_y | sat_z;
            r_out.grid_done <= r_s3_done;
        end
    end

    assign d_hx = curl_diff(r_nz.ey, r_s1.ey_in, ny.ez, r_s1.ez_in);
    assign d_hy = curl_diff(nx.ez, r_s1.ez_in, r_nz.ex, r_s1.ex_in);
    assign d_hz = curl_diff(ny.ex, r_s1.ex_in, nx.ey, r_s1.ey_in);

    fdtd_h_update u_hx (
        .i_clk    (i_clk),
        .i_en_mag (adv2),
        .i_en_mul (adv3),
        .i_upd    (r_s1_bound.ny_ok & r_s1_bound.nz_ok),
        .i_h      (r_s1.hx_in),
        .i_d      (d_hx),
        .i_coef   (cfg.update_coefficient),
        .o_h      (hx),
        .o_sat    (sat_x)
    );

    fdtd_h_update u_hy (
        .i_clk    (i_clk),
        .i_en_mag (adv2),
        .i_en_mul (adv3),
        .i_upd    (r_s1_bound.nx_ok & r_s1_bound.nz_ok),
        .i_h      (r_s1.hy_in),
        .i_d      (d_hy),
        .i_coef   (cfg.update_coefficient),
        .o_h      (hy),
        .o_sat    (sat_y)
    );

    fdtd_h_update u_hz (
        .i_clk    (i_clk),
        .i_en_mag (adv2),
        .i_en_mul (adv3),
        .i_upd    (r_s1_bound.nx_ok & r_s1_bound.ny_ok),
        .i_h      (r_s1.hz_in),
        .i_d      (d_hz),
        .i_coef   (cfg.update_coefficient),
        .o_h      (hz),
        .o_sat    (sat_z)
    );

    assign o_out_valid = r_vo;
    assign o_out_data  = r_out;

endmodule
